// ===== rtl/hcd_pkg.sv =====
// Shared constants, codes and types of the canonical Huffman decoder.
package hcd_pkg;

	localparam int MAX_CODE_LENGTH = 16;
	localparam int SYMBOL_DEPTH    = 256;
	localparam int NUM_LENGTHS     = 16;
	localparam int CODE_W          = 16;
	localparam int MAXC_W          = 17;
	localparam int CNT_W           = 9;
	localparam int CNT_SAT         = 511;
	localparam int SYM_AW          = $clog2(SYMBOL_DEPTH);
	localparam int LEN_W           = 5;
	localparam int IDX_W           = 4;
	localparam int OFF_W           = 19;
	localparam logic [7:0] ERR_SYMBOL = 8'hFF;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DECODED  = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [MAXC_W-1:0] max_code;
		logic [CODE_W-1:0] min_code;
		logic [CNT_W-1:0]  value_pointer;
	} len_entry_t;

	typedef struct packed {
		logic              we;
		logic [SYM_AW-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic              emit;
		logic              use_store;
		logic [LEN_W-1:0]  length;
		status_t           status;
		logic [SYM_AW-1:0] addr;
	} dec_result_t;

endpackage

// ===== rtl/hcd_symbol_store.sv =====
// Symbol store: one write port, one registered read port.
module hcd_symbol_store (
	input  logic                      clk,
	input  hcd_pkg::store_wr_t        wr,
	input  logic                      rd_en,
	input  logic [hcd_pkg::SYM_AW-1:0] rd_addr,
	output logic [7:0]                rd_data
);

	logic [7:0] mem [hcd_pkg::SYMBOL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/hcd_table_build.sv =====
// Table builder: per-length mincode, maxcode and value pointer from DHT bytes.
module hcd_table_build (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  logic                table_start,
	input  logic [7:0]          table_byte,
	output hcd_pkg::len_entry_t tables [hcd_pkg::NUM_LENGTHS],
	output hcd_pkg::store_wr_t  wr,
	output logic                overflow
);

	hcd_pkg::len_entry_t             tables_q [hcd_pkg::NUM_LENGTHS];
	logic [hcd_pkg::IDX_W:0]         load_index_q;
	logic [hcd_pkg::MAXC_W-1:0]      build_code_q;
	logic [hcd_pkg::CNT_W-1:0]       symbol_total_q;
	logic [hcd_pkg::CNT_W-1:0]       symbols_loaded_q;

	logic [hcd_pkg::IDX_W:0]         idx_eff;
	logic [hcd_pkg::IDX_W-1:0]       idx_sel;
	logic [hcd_pkg::MAXC_W-1:0]      build_eff;
	logic [hcd_pkg::CNT_W-1:0]       total_eff;
	logic [hcd_pkg::CNT_W-1:0]       loaded_eff;
	logic                            count_phase;
	logic [hcd_pkg::CNT_W:0]         total_sum;
	logic [hcd_pkg::CNT_W-1:0]       total_next;
	logic [hcd_pkg::MAXC_W-1:0]      build_plus;
	logic [hcd_pkg::MAXC_W-1:0]      build_next;
	logic [hcd_pkg::MAXC_W-1:0]      max_new;
	logic                            pending;
	logic                            in_store;
	logic [hcd_pkg::IDX_W:0]         idx_upd;
	logic [hcd_pkg::MAXC_W-1:0]      build_upd;
	logic [hcd_pkg::CNT_W-1:0]       total_upd;
	logic [hcd_pkg::CNT_W-1:0]       loaded_upd;

	// A table start clears the build state before this byte is used.
	always_comb begin
		idx_eff     = table_start ? '0 : load_index_q;
		idx_sel     = idx_eff[hcd_pkg::IDX_W-1:0];
		build_eff   = table_start ? '0 : build_code_q;
		total_eff   = table_start ? '0 : symbol_total_q;
		loaded_eff  = table_start ? '0 : symbols_loaded_q;
		count_phase = idx_eff < (hcd_pkg::IDX_W + 1)'(hcd_pkg::NUM_LENGTHS);
		total_sum   = {1'b0, total_eff} + (hcd_pkg::CNT_W + 1)'(table_byte);
		total_next  = (total_sum > (hcd_pkg::CNT_W + 1)'(hcd_pkg::CNT_SAT)) ?
			'1 : total_sum[hcd_pkg::CNT_W-1:0];
		build_plus  = build_eff + hcd_pkg::MAXC_W'(table_byte);
		build_next  = {build_plus[hcd_pkg::MAXC_W-2:0], 1'b0};
		max_new     = build_plus - hcd_pkg::MAXC_W'(1);
		pending     = loaded_eff < total_eff;
		in_store    = loaded_eff < hcd_pkg::CNT_W'(hcd_pkg::SYMBOL_DEPTH);
		idx_upd     = count_phase ? idx_eff + (hcd_pkg::IDX_W + 1)'(1) : idx_eff;
		build_upd   = count_phase ? build_next : build_eff;
		total_upd   = count_phase ? total_next : total_eff;
		// past the store, the count saturates at CNT_SAT
		loaded_upd  = (!count_phase && pending &&
			(in_store || loaded_eff != hcd_pkg::CNT_W'(hcd_pkg::CNT_SAT))) ?
			loaded_eff + hcd_pkg::CNT_W'(1) : loaded_eff;
	end

	always_comb begin
		wr.we    = load_en && !count_phase && pending && in_store;
		wr.addr  = loaded_eff[hcd_pkg::SYM_AW-1:0];
		wr.data  = table_byte;
		overflow = load_en && !count_phase && pending && !in_store;
	end

	assign tables = tables_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hcd_pkg::NUM_LENGTHS; i++) begin
				tables_q[i].max_code      <= '1;
				tables_q[i].min_code      <= '0;
				tables_q[i].value_pointer <= '0;
			end
			load_index_q     <= '0;
			build_code_q     <= '0;
			symbol_total_q   <= '0;
			symbols_loaded_q <= '0;
		end else if (load_en) begin
			for (int i = 0; i < hcd_pkg::NUM_LENGTHS; i++) begin
				if (count_phase && idx_sel == hcd_pkg::IDX_W'(i)) begin
					if (table_byte != 8'd0) begin
						tables_q[i].value_pointer <= total_eff;
						tables_q[i].min_code      <= build_eff[hcd_pkg::CODE_W-1:0];
						tables_q[i].max_code      <= max_new;
					end else begin
						tables_q[i].value_pointer <= '0;
						tables_q[i].min_code      <= '0;
						tables_q[i].max_code      <= '1;
					end
				end else if (table_start) begin
					tables_q[i].max_code <= '1;
				end
			end
			load_index_q     <= idx_upd;
			build_code_q     <= build_upd;
			symbol_total_q   <= total_upd;
			symbols_loaded_q <= loaded_upd;
		end
	end

endmodule

// ===== rtl/hcd_code_match.sv =====
// Code matcher: shifts in one bit and compares against maxcode at that length.
module hcd_code_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dec_en,
	input  logic                 code_bit,
	input  hcd_pkg::len_entry_t  tables [hcd_pkg::NUM_LENGTHS],
	output hcd_pkg::dec_result_t res
);

	logic [hcd_pkg::CODE_W-1:0] acc_q;
	logic [hcd_pkg::LEN_W-1:0]  bits_q;

	logic [hcd_pkg::CODE_W-1:0] acc_sh;
	logic [hcd_pkg::LEN_W-1:0]  len;
	logic [hcd_pkg::LEN_W-1:0]  len_m1;
	hcd_pkg::len_entry_t        ent;
	logic                       hit;
	logic                       no_match;
	logic [hcd_pkg::OFF_W-1:0]  off;
	logic                       in_range;

	always_comb begin
		acc_sh = {acc_q[hcd_pkg::CODE_W-2:0], code_bit};
		len    = (bits_q < hcd_pkg::LEN_W'(hcd_pkg::MAX_CODE_LENGTH)) ?
			bits_q + hcd_pkg::LEN_W'(1) : bits_q;
		len_m1 = len - hcd_pkg::LEN_W'(1);
		ent    = tables[len_m1[hcd_pkg::IDX_W-1:0]];
		// a maxcode with its top bit set is negative: never matches
		hit    = !ent.max_code[hcd_pkg::MAXC_W-1] &&
			({1'b0, acc_sh} <= ent.max_code);
		no_match = !hit && (len >= hcd_pkg::LEN_W'(hcd_pkg::MAX_CODE_LENGTH));
		// two's complement offset; the sign bit flags a negative result
		off = hcd_pkg::OFF_W'(ent.value_pointer) + hcd_pkg::OFF_W'(acc_sh)
			- hcd_pkg::OFF_W'(ent.min_code);
		in_range = !off[hcd_pkg::OFF_W-1] &&
			(off < hcd_pkg::OFF_W'(hcd_pkg::SYMBOL_DEPTH));
	end

	always_comb begin
		res.emit      = dec_en && (hit || no_match);
		res.use_store = hit && in_range;
		res.length    = len;
		res.addr      = off[hcd_pkg::SYM_AW-1:0];
		if (!hit) begin
			res.status = hcd_pkg::ST_NO_MATCH;
		end else if (in_range) begin
			res.status = hcd_pkg::ST_DECODED;
		end else begin
			res.status = hcd_pkg::ST_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bits_q <= '0;
		end else if (dec_en) begin
			if (hit || no_match) begin
				acc_q  <= '0;
				bits_q <= '0;
			end else begin
				acc_q  <= acc_sh;
				bits_q <= len;
			end
		end
	end

endmodule

// ===== rtl/jpeg_canonical_huffman_decoder_top.sv =====
// An input word is registered in stage one, its result in stage two. Throughput:
// one input word per cycle unless the output stalls; each bit needs one maxcode
// compare and the symbol store is read once, its registered read data feeding
// the output. While a result waits, an input word is taken only into an empty
// stage one. Reset (arst_n low, asynchronous) empties both stages, clears the
// code and sets every maxcode to no codes; the symbol store is not cleared.
module jpeg_canonical_huffman_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic        table_start,
	input  logic [7:0]  table_byte,
	input  logic        code_bit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  symbol,
	output logic [4:0]  code_length,
	output logic [1:0]  status
);

	logic                       valid_s1;
	hcd_pkg::cmd_t              cmd_s1;
	logic                       start_s1;
	logic [7:0]                 byte_s1;
	logic                       bit_s1;

	logic                       valid_s2;
	logic                       use_store_s2;
	logic [hcd_pkg::LEN_W-1:0]  len_s2;
	hcd_pkg::status_t           status_s2;

	logic                       s2_free;
	logic                       advance;
	logic                       load_en;
	logic                       dec_en;
	logic                       overflow;
	hcd_pkg::len_entry_t        tables [hcd_pkg::NUM_LENGTHS];
	hcd_pkg::store_wr_t         wr;
	hcd_pkg::dec_result_t       dec;
	logic [7:0]                 rd_data;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign load_en  = advance && (cmd_s1 == hcd_pkg::CMD_LOAD);
	assign dec_en   = advance && (cmd_s1 == hcd_pkg::CMD_DECODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= hcd_pkg::cmd_t'(command);
			start_s1 <= table_start;
			byte_s1  <= table_byte;
			bit_s1   <= code_bit;
		end
	end

	hcd_table_build u_build (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_en     (load_en),
		.table_start (start_s1),
		.table_byte  (byte_s1),
		.tables      (tables),
		.wr          (wr),
		.overflow    (overflow)
	);

	hcd_code_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.dec_en   (dec_en),
		.code_bit (bit_s1),
		.tables   (tables),
		.res      (dec)
	);

	hcd_symbol_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (dec.emit && dec.use_store),
		.rd_addr (dec.addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= overflow || dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd_s1 == hcd_pkg::CMD_LOAD) begin
				use_store_s2 <= 1'b0;
				len_s2       <= '0;
				status_s2    <= hcd_pkg::ST_OVERFLOW;
			end else begin
				use_store_s2 <= dec.use_store;
				len_s2       <= dec.length;
				status_s2    <= dec.status;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign symbol      = use_store_s2 ? rd_data : hcd_pkg::ERR_SYMBOL;
	assign code_length = len_s2;
	assign status      = status_s2;

endmodule

// ===== rtl/hcd_checker.sv =====
// Port-level checker for the canonical Huffman decoder, bound to the top level.
module hcd_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  symbol,
	input logic [4:0]  code_length,
	input logic [1:0]  status
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol) &&
		$stable(code_length) && $stable(status))
		else $error("result word changed while stalled");

	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hcd_pkg::ST_NO_MATCH |->
		code_length == 5'(hcd_pkg::MAX_CODE_LENGTH) && symbol == hcd_pkg::ERR_SYMBOL)
		else $error("no-match word with bad length or symbol");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hcd_pkg::ST_OVERFLOW |-> symbol == hcd_pkg::ERR_SYMBOL)
		else $error("overflow word without error symbol");

	a_decoded_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hcd_pkg::ST_DECODED |->
		code_length != 5'd0 && code_length <= 5'(hcd_pkg::MAX_CODE_LENGTH))
		else $error("decoded word with bad code length");

	// a free output stage never holds off input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind jpeg_canonical_huffman_decoder_top hcd_port_checker u_hcd_checker (.*);

// ===== tb/sv/hcd_checker.sv =====
// Checker for the canonical Huffman decoder: predicts every result word and compares it.
`timescale 1ns / 1ps
module hcd_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       command,
	input  logic       table_start,
	input  logic [7:0] table_byte,
	input  logic       code_bit,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] symbol,
	input  logic [4:0] code_length,
	input  logic [1:0] status,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0]                sym;
		logic [hcd_pkg::LEN_W-1:0] len;
		hcd_pkg::status_t          st;
	} result_word_t;

	logic [hcd_pkg::MAXC_W-1:0] max_tab  [hcd_pkg::NUM_LENGTHS];
	logic [hcd_pkg::CODE_W-1:0] min_tab  [hcd_pkg::NUM_LENGTHS];
	logic [hcd_pkg::CNT_W-1:0]  vptr_tab [hcd_pkg::NUM_LENGTHS];
	logic [7:0]                 store    [hcd_pkg::SYMBOL_DEPTH];
	logic [hcd_pkg::CNT_W-1:0]  count_idx;
	logic [hcd_pkg::MAXC_W-1:0] next_code;
	logic [hcd_pkg::CNT_W-1:0]  sym_total;
	logic [hcd_pkg::CNT_W-1:0]  sym_loaded;
	logic [hcd_pkg::CODE_W-1:0] acc;
	logic [hcd_pkg::LEN_W-1:0]  nbits;
	result_word_t               sym_queue [$];
	int                         mismatches = 0;

	assign fail_count = mismatches;

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	function automatic void queue_word(input result_word_t w);
		sym_queue.insert(sym_queue.size(), w);
	endfunction

	function automatic void clear_table();
		int i;
		for (i = 0; i < hcd_pkg::NUM_LENGTHS; i++)
			max_tab[i] = '1;
		count_idx  = '0;
		next_code  = '0;
		sym_total  = '0;
		sym_loaded = '0;
	endfunction

	function automatic void clear_all();
		int i;
		for (i = 0; i < hcd_pkg::NUM_LENGTHS; i++) begin
			min_tab[i]  = '0;
			vptr_tab[i] = '0;
		end
		for (i = 0; i < hcd_pkg::SYMBOL_DEPTH; i++)
			store[i] = '0;
		clear_table();
		acc   = '0;
		nbits = '0;
		sym_queue.delete();
	endfunction

	function automatic void huff_step(input hcd_pkg::cmd_t cmd, input logic restart,
			input logic [7:0] tbyte, input logic cbit);
		int                       k;
		int                       t;
		int                       off;
		int                       len;
		logic [hcd_pkg::MAXC_W:0] sum;
		result_word_t             w;
		if (cmd == hcd_pkg::CMD_LOAD) begin
			if (restart)
				clear_table();
			if (count_idx < hcd_pkg::NUM_LENGTHS) begin
				k = count_idx;
				if (tbyte != 0) begin
					vptr_tab[k] = sym_total;
					min_tab[k]  = next_code[hcd_pkg::CODE_W-1:0];
					max_tab[k]  = next_code + tbyte - 1'b1;
				end else begin
					vptr_tab[k] = '0;
					min_tab[k]  = '0;
					max_tab[k]  = '1;
				end
				t = sym_total + tbyte;
				if (t > hcd_pkg::CNT_SAT)
					t = hcd_pkg::CNT_SAT;
				sym_total = t[hcd_pkg::CNT_W-1:0];
				sum = next_code + tbyte;
				next_code = {sum[hcd_pkg::CODE_W-1:0], 1'b0};
				count_idx++;
			end else if (sym_loaded < sym_total) begin
				if (sym_loaded < hcd_pkg::SYMBOL_DEPTH) begin
					store[sym_loaded] = tbyte;
					sym_loaded++;
				end else begin
					// store full: drop the word and flag it
					if (sym_loaded < hcd_pkg::CNT_SAT)
						sym_loaded++;
					w.sym = hcd_pkg::ERR_SYMBOL;
					w.len = '0;
					w.st  = hcd_pkg::ST_OVERFLOW;
					queue_word(w);
				end
			end
		end else begin
			acc = {acc[hcd_pkg::CODE_W-2:0], cbit};
			if (nbits < hcd_pkg::MAX_CODE_LENGTH)
				nbits++;
			len = nbits;
			if (len >= 1 && len <= hcd_pkg::NUM_LENGTHS &&
					$signed({1'b0, acc}) <= $signed(max_tab[len-1])) begin
				off = int'(vptr_tab[len-1]) + int'(acc) - int'(min_tab[len-1]);
				acc   = '0;
				nbits = '0;
				w.len = len[hcd_pkg::LEN_W-1:0];
				if (off < 0 || off >= hcd_pkg::SYMBOL_DEPTH) begin
					w.sym = hcd_pkg::ERR_SYMBOL;
					w.st  = hcd_pkg::ST_OVERFLOW;
				end else begin
					w.sym = store[off];
					w.st  = hcd_pkg::ST_DECODED;
				end
				queue_word(w);
			end else if (len >= hcd_pkg::MAX_CODE_LENGTH) begin
				acc   = '0;
				nbits = '0;
				w.sym = hcd_pkg::ERR_SYMBOL;
				w.len = len[hcd_pkg::LEN_W-1:0];
				w.st  = hcd_pkg::ST_NO_MATCH;
				queue_word(w);
			end
		end
	endfunction

	task automatic check_word();
		result_word_t want;
		if (sym_queue.size() == 0) begin
			flag_mismatch($sformatf("word with none expected: symbol %0d length %0d status %0d",
				symbol, code_length, status));
		end else begin
			want = sym_queue.pop_front();
			if (symbol !== want.sym)
				flag_mismatch($sformatf("symbol %0d, want %0d", symbol, want.sym));
			if (code_length !== want.len)
				flag_mismatch($sformatf("code_length %0d, want %0d", code_length, want.len));
			if (status !== want.st)
				flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_all();
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_word();
			if (in_valid && in_ready)
				huff_step(hcd_pkg::cmd_t'(command), table_start, table_byte, code_bit);
			pending <= sym_queue.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the canonical Huffman decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int     HALF_PERIOD  = 10;
	localparam int     RANDOM_WORDS = 1800;
	localparam int     LONG_HOLD    = 300;
	localparam int     DRAIN_CYCLES = 64;
	localparam longint LIMIT_NS     = 64'd20_000_000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	hcd_pkg::cmd_t command;
	logic          table_start;
	logic [7:0]    table_byte;
	logic          code_bit;
	logic          out_valid;
	logic          out_ready;
	logic [7:0]    symbol;
	logic [4:0]    code_length;
	logic [1:0]    status;

	int fail_count;
	int pending;
	int words_sent = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_req = 1'b0;
	bit table_valid = 1'b0;
	int table_counts [hcd_pkg::NUM_LENGTHS];

	jpeg_canonical_huffman_decoder_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.table_start (table_start),
		.table_byte  (table_byte),
		.code_bit    (code_bit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.symbol      (symbol),
		.code_length (code_length),
		.status      (status)
	);

	hcd_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.table_start (table_start),
		.table_byte  (table_byte),
		.code_bit    (code_bit),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.symbol      (symbol),
		.code_length (code_length),
		.status      (status),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_word(input hcd_pkg::cmd_t c, input logic restart,
			input logic [7:0] tbyte, input logic cbit);
		int g;
		g = pick_gap(tx_quiet);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= c;
		table_start <= restart;
		table_byte  <= tbyte;
		code_bit    <= cbit;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// code_bit has no role on a load, table_start and table_byte none on a decode
	task automatic send_load(input logic restart, input logic [7:0] tbyte);
		send_word(hcd_pkg::CMD_LOAD, restart, tbyte, 1'($urandom));
	endtask

	task automatic send_bit(input logic cbit);
		send_word(hcd_pkg::CMD_DECODE, 1'($urandom), 8'($urandom), cbit);
	endtask

	task automatic send_symbols(input int n);
		repeat (n) send_load(1'b0, 8'($urandom));
	endtask

	task automatic load_counts();
		int len;
		for (len = 0; len < hcd_pkg::NUM_LENGTHS; len++)
			send_load(len == 0, 8'(table_counts[len]));
	endtask

	// hold valid low until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int table_total();
		int s;
		int len;
		s = 0;
		for (len = 0; len < hcd_pkg::NUM_LENGTHS; len++)
			s += table_counts[len];
		return (s > hcd_pkg::CNT_SAT) ? hcd_pkg::CNT_SAT : s;
	endfunction

	// counts that keep the code prefix-free, leaving room below the last length
	function automatic void make_regular_table();
		int code;
		int room;
		int cap;
		int len;
		code = 0;
		for (len = 1; len <= hcd_pkg::NUM_LENGTHS; len++) begin
			room = (1 << len) - code;
			cap = (room - 1 > 6) ? 6 : room - 1;
			if (cap < 0)
				cap = 0;
			table_counts[len-1] = ($urandom_range(0, 2) != 0) ? $urandom_range(0, cap) : 0;
			code = (code + table_counts[len-1]) << 1;
		end
	endfunction

	// oversized counts push the canonical code past 17 bits
	function automatic void make_wild_table();
		int len;
		int r;
		for (len = 0; len < hcd_pkg::NUM_LENGTHS; len++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				table_counts[len] = $urandom_range(0, 255);
			else if (r < 4)
				table_counts[len] = $urandom_range(0, 3);
			else
				table_counts[len] = 0;
		end
	endfunction

	// send the canonical code of symbol number idx, most significant bit first
	task automatic send_code(input int idx);
		int code;
		int len;
		int b;
		bit found;
		code = 0;
		found = 1'b0;
		for (len = 1; len <= hcd_pkg::NUM_LENGTHS && !found; len++) begin
			if (idx < table_counts[len-1]) begin
				found = 1'b1;
				for (b = len - 1; b >= 0; b--)
					send_bit(1'((code + idx) >> b));
			end else begin
				idx -= table_counts[len-1];
				code = (code + table_counts[len-1]) << 1;
			end
		end
	endtask

	task automatic new_table();
		int n;
		if ($urandom_range(0, 6) == 0) begin
			make_wild_table();
			load_counts();
			n = ($urandom_range(0, 3) == 0) ? table_total() : $urandom_range(0, 20);
		end else begin
			make_regular_table();
			load_counts();
			n = table_total();
		end
		send_symbols(n + $urandom_range(0, 2));
		table_valid = 1'b1;
	endtask

	initial begin
		int  r;
		int  k;
		int  i;
		int  total;
		bit  hold_done;
		hold_done   = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		command     <= hcd_pkg::CMD_LOAD;
		table_start <= 1'b0;
		table_byte  <= 8'h00;
		code_bit    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two-code table: one code of length 1, one of length 2, then a surplus byte
		table_counts = '{default: 0};
		table_counts[0] = 1;
		table_counts[1] = 1;
		load_counts();
		send_load(1'b0, 8'h00);
		send_load(1'b0, 8'hFF);
		send_load(1'b0, 8'h5A);
		table_valid = 1'b1;
		send_code(0);
		send_code(1);
		// all ones never matches this table
		repeat (hcd_pkg::MAX_CODE_LENGTH) send_bit(1'b1);
		drain();

		// long table: fills every store entry, overflows it, and codes point past it
		table_counts = '{default: 0};
		table_counts[8] = 255;
		table_counts[9] = 100;
		load_counts();
		send_symbols(table_total() + 2);
		repeat (40) send_code($urandom_range(0, table_total() - 1));
		repeat (20) send_bit(1'($urandom));
		drain();

		while (words_sent < RANDOM_WORDS) begin
			if (!hold_done && words_sent > RANDOM_WORDS / 2) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			tx_quiet = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0)
				drain();
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if (!table_valid || $urandom_range(0, 3) == 0)
					new_table();
				total = table_total();
				if (total > 0)
					repeat ($urandom_range(4, 24)) send_code($urandom_range(0, total - 1));
				else
					repeat ($urandom_range(1, 20)) send_bit(1'($urandom));
			end else if (r < 88) begin
				repeat ($urandom_range(1, 20)) send_bit(1'($urandom));
			end else if (r < 95) begin
				// broken table: restart, stop partway through the counts or symbols
				k = $urandom_range(1, hcd_pkg::NUM_LENGTHS);
				for (i = 0; i < k; i++)
					send_load(i == 0, 8'($urandom_range(0, 8)));
				if (k == hcd_pkg::NUM_LENGTHS)
					send_symbols($urandom_range(0, 3));
				table_valid = 1'b0;
			end else begin
				send_symbols($urandom_range(1, 3));
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int stall;
		int run;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				// long hold: let the block fill up and stall its input
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = pick_gap(rx_quiet);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			if ($urandom_range(0, 15) == 0)
				rx_quiet = !rx_quiet;
		end
	end

endmodule
